@@ design/tnef_pkg.sv @@
// Shared types and constants for the TNEF record deframer.
`default_nettype none
package tnef_pkg;

  // Little-endian stream signature that opens every TNEF stream.
  localparam logic [31:0] SIGNATURE_WORD = 32'h223E_9F78;

  // Event kinds carried on the result channel.
  localparam logic [1:0] EV_DATA     = 2'd0;
  localparam logic [1:0] EV_CSUM_OK  = 2'd1;
  localparam logic [1:0] EV_CSUM_ERR = 2'd2;
  localparam logic [1:0] EV_SIG_ERR  = 2'd3;

  // Depth of the event queue between parser and result port.
  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int unsigned EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  // One result event as produced by the parser.
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] attribute_type;
    logic [7:0]  component;
    logic [7:0]  payload_byte;
    logic [31:0] record_length;
    logic        last_of_record;
  } tnef_event_t;

endpackage
`default_nettype wire

@@ design/tnef_record_deframer_core.sv @@
// Top level of the TNEF record deframer: parser front end and result queue back end.
//
// Usage: the stream enters one byte per request on the input queue port.
// A byte is taken at a rising edge where push is high and full is low; set
// in_restart on the first byte of every new stream. The block checks the
// four-byte signature, skips the two-byte key and then parses records.
// Each data byte leaves as one result request tagged with its record's
// component, attribute type and length; after the checksum word a request
// reports whether the record's 16-bit sum matched. A bad signature or a bad
// checksum is reported once, after which the block ignores bytes until a
// restart. Header, key and checksum bytes that complete nothing give no
// result.
// Latency: a result caused by a byte enters the queue at the edge that takes
// the byte, so with no older result waiting it is on the out_ ports (empty
// low) in the following cycle. Throughput: one byte per cycle while the queue
// has room; while full is high no further byte is taken.
// Results wait in a four-entry queue; when the receiver stops popping, the
// queue fills and full rises so that no byte is taken until room returns.
// Reset (rst_n low at a clock edge) empties the queue and returns the
// parser to its signature-search state.
`default_nettype none
module tnef_record_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_restart,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_event_kind,
  output logic [31:0]      out_attribute_type,
  output logic [7:0]       out_component,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_record_length,
  output logic             out_last_of_record
);

  logic                   byte_take;
  logic                   ev_valid;
  tnef_pkg::tnef_event_t  ev;
  tnef_pkg::tnef_event_t  head_ev;
  logic                   q_full;
  logic                   q_empty;

  // Every accepted byte yields at most one event, so holding off input
  // while the queue is full is enough to guarantee it never overflows.
  assign byte_take = push & ~q_full;

  tnef_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_take),
    .stream_byte (in_stream_byte),
    .restart     (in_restart),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  tnef_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_valid),
    .wr_ev   (ev),
    .rd_en   (pop & ~q_empty),
    .rd_ev   (head_ev),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  assign full               = q_full;
  assign empty              = q_empty;
  assign out_event_kind     = head_ev.event_kind;
  assign out_attribute_type = head_ev.attribute_type;
  assign out_component      = head_ev.component;
  assign out_payload_byte   = head_ev.payload_byte;
  assign out_record_length  = head_ev.record_length;
  assign out_last_of_record = head_ev.last_of_record;

endmodule
`default_nettype wire

@@ design/tnef_parser.sv @@
// Front end: byte-wise TNEF stream parser that classifies each byte and emits events.
`default_nettype none
module tnef_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_valid,
  input  wire logic [7:0]           stream_byte,
  input  wire logic                 restart,
  output logic                      ev_valid,
  output tnef_pkg::tnef_event_t     ev
);

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_KEY  = 3'd1;
  localparam logic [2:0] PH_COMP = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_LEN  = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;
  localparam logic [2:0] PH_HALT = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] rtype_r, rtype_nxt;
  logic [7:0]  rcomp_r, rcomp_nxt;
  logic [31:0] rsize_r, rsize_nxt;
  logic [31:0] left_r, left_nxt;
  logic [15:0] sum_r, sum_nxt;

  // State as seen by this byte: a restart byte starts from the reset state.
  logic [2:0]  eff_phase;
  logic [1:0]  eff_cnt;
  logic [31:0] eff_acc;
  logic [31:0] eff_rtype;
  logic [7:0]  eff_rcomp;
  logic [31:0] eff_rsize;
  logic [31:0] eff_left;
  logic [15:0] eff_sum;

  logic [31:0] gathered;
  logic [31:0] left_dec;
  logic [15:0] sum_inc;
  logic        ev_gen;

  always_comb begin
    eff_phase = restart ? PH_SIG : phase_r;
    eff_cnt   = restart ? 2'd0   : cnt_r;
    eff_acc   = restart ? 32'd0  : acc_r;
    eff_rtype = restart ? 32'd0  : rtype_r;
    eff_rcomp = restart ? 8'd0   : rcomp_r;
    eff_rsize = restart ? 32'd0  : rsize_r;
    eff_left  = restart ? 32'd0  : left_r;
    eff_sum   = restart ? 16'd0  : sum_r;
  end

  assign gathered = eff_acc | ({24'd0, stream_byte} << {eff_cnt, 3'b000});
  assign left_dec = eff_left - 32'd1;
  assign sum_inc  = eff_sum + {8'd0, stream_byte};

  always_comb begin
    phase_nxt = eff_phase;
    cnt_nxt   = eff_cnt;
    acc_nxt   = eff_acc;
    rtype_nxt = eff_rtype;
    rcomp_nxt = eff_rcomp;
    rsize_nxt = eff_rsize;
    left_nxt  = eff_left;
    sum_nxt   = eff_sum;
    ev_gen    = 1'b0;
    ev        = '0;

    unique case (eff_phase)
      PH_SIG: begin
        if (eff_cnt == 2'd3) begin
          cnt_nxt = 2'd0;
          acc_nxt = 32'd0;
          if (gathered == tnef_pkg::SIGNATURE_WORD) begin
            phase_nxt = PH_KEY;
          end else begin
            phase_nxt     = PH_HALT;
            ev_gen        = 1'b1;
            ev.event_kind = tnef_pkg::EV_SIG_ERR;
          end
        end else begin
          cnt_nxt = eff_cnt + 2'd1;
          acc_nxt = gathered;
        end
      end
      PH_KEY: begin
        if (eff_cnt == 2'd1) begin
          cnt_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          phase_nxt = PH_COMP;
        end else begin
          cnt_nxt = eff_cnt + 2'd1;
          acc_nxt = gathered;
        end
      end
      PH_COMP: begin
        rcomp_nxt = stream_byte;
        cnt_nxt   = 2'd0;
        acc_nxt   = 32'd0;
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        if (eff_cnt == 2'd3) begin
          rtype_nxt = gathered;
          cnt_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          phase_nxt = PH_LEN;
        end else begin
          cnt_nxt = eff_cnt + 2'd1;
          acc_nxt = gathered;
        end
      end
      PH_LEN: begin
        if (eff_cnt == 2'd3) begin
          rsize_nxt = gathered;
          left_nxt  = gathered;
          cnt_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          sum_nxt   = 16'd0;
          // An empty record carries neither data nor a checksum word.
          phase_nxt = (gathered == 32'd0) ? PH_COMP : PH_DATA;
        end else begin
          cnt_nxt = eff_cnt + 2'd1;
          acc_nxt = gathered;
        end
      end
      PH_DATA: begin
        sum_nxt           = sum_inc;
        left_nxt          = left_dec;
        ev_gen            = 1'b1;
        ev.event_kind     = tnef_pkg::EV_DATA;
        ev.attribute_type = eff_rtype;
        ev.component      = eff_rcomp;
        ev.payload_byte   = stream_byte;
        ev.record_length  = eff_rsize;
        ev.last_of_record = (left_dec == 32'd0);
        if (left_dec == 32'd0) begin
          cnt_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (eff_cnt == 2'd1) begin
          cnt_nxt           = 2'd0;
          acc_nxt           = 32'd0;
          ev_gen            = 1'b1;
          ev.attribute_type = eff_rtype;
          ev.component      = eff_rcomp;
          ev.record_length  = eff_rsize;
          if (gathered[15:0] == eff_sum) begin
            phase_nxt     = PH_COMP;
            ev.event_kind = tnef_pkg::EV_CSUM_OK;
          end else begin
            phase_nxt     = PH_HALT;
            ev.event_kind = tnef_pkg::EV_CSUM_ERR;
          end
        end else begin
          cnt_nxt = eff_cnt + 2'd1;
          acc_nxt = gathered;
        end
      end
      PH_HALT: begin
      end
    endcase
  end

  assign ev_valid = byte_valid & ev_gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      cnt_r   <= 2'd0;
      acc_r   <= 32'd0;
      rtype_r <= 32'd0;
      rcomp_r <= 8'd0;
      rsize_r <= 32'd0;
      left_r  <= 32'd0;
      sum_r   <= 16'd0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      rtype_r <= rtype_nxt;
      rcomp_r <= rcomp_nxt;
      rsize_r <= rsize_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_data_only_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev.event_kind == tnef_pkg::EV_DATA) |-> (eff_phase == PH_DATA))
    else $error("data event outside the data phase");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && (ev.event_kind == tnef_pkg::EV_CSUM_ERR ||
                  ev.event_kind == tnef_pkg::EV_SIG_ERR)) |=> (phase_r == PH_HALT))
    else $error("error event did not halt the parser");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT && !(byte_valid && restart)) |=> (phase_r == PH_HALT))
    else $error("parser left the halted state without a restart");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT && !restart) |-> !ev_valid)
    else $error("halted parser produced an event");
`endif

endmodule
`default_nettype wire

@@ design/tnef_evq.sv @@
// Back end: short event queue that holds parser results until the receiver pops them.
`default_nettype none
module tnef_evq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  tnef_pkg::tnef_event_t     wr_ev,
  input  wire logic                 rd_en,
  output tnef_pkg::tnef_event_t     rd_ev,
  output logic                      q_full,
  output logic                      q_empty
);

  tnef_pkg::tnef_event_t            slot_r [tnef_pkg::EVQ_DEPTH];
  logic [tnef_pkg::EVQ_PTR_W-1:0]   wr_ptr_r;
  logic [tnef_pkg::EVQ_PTR_W-1:0]   rd_ptr_r;
  logic [tnef_pkg::EVQ_CNT_W-1:0]   count_r;
  logic [tnef_pkg::EVQ_CNT_W-1:0]   count_nxt;

  assign q_full  = (count_r == tnef_pkg::EVQ_CNT_W'(tnef_pkg::EVQ_DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_ev   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_tnef_record_deframer_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the TNEF record deframer core, with a byte-level predictor.
module tb_tnef_record_deframer_core;

  // Run shape. The stall limit covers the long receiver hold-off below plus
  // generous margin for random gaps on both sides.
  localparam int unsigned STREAM_ITEMS   = 1500;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned RX_HOLD_AFTER  = 700;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned QUIET_FROM     = 400;
  localparam int unsigned QUIET_TO       = 900;
  localparam int unsigned IDLE_PERCENT   = 8;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One byte request as offered on the input side.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } stream_item_t;

  // Parser phases, mirrored in the predictor below.
  typedef enum logic [2:0] {
    P_SIG, P_KEY, P_COMP, P_TYPE, P_LEN, P_DATA, P_CSUM, P_HALT
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_event_kind;
  logic [31:0] out_attribute_type;
  logic [7:0]  out_component;
  logic [7:0]  out_payload_byte;
  logic [31:0] out_record_length;
  logic        out_last_of_record;

  tnef_record_deframer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_stream_byte     (in_stream_byte),
    .in_restart         (in_restart),
    .empty              (empty),
    .pop                (pop),
    .out_event_kind     (out_event_kind),
    .out_attribute_type (out_attribute_type),
    .out_component      (out_component),
    .out_payload_byte   (out_payload_byte),
    .out_record_length  (out_record_length),
    .out_last_of_record (out_last_of_record)
  );

  // 8 ns period, high phase first.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Byte requests still to be offered, and events the predictor is owed.
  stream_item_t          pending_bytes[$];
  tnef_pkg::tnef_event_t expected_events[$];

  int unsigned counted_items = 0;
  int unsigned inputs_taken  = 0;
  int unsigned cycle_count   = 0;
  int unsigned stall_cycles  = 0;
  int unsigned mismatches    = 0;
  bit          byte_taken    = 1'b0;

  // Neither side idles at random inside this window, so the block sees a long
  // back-to-back run of requests in both directions.
  wire quiet_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the parser's registers.
  // ---------------------------------------------------------------------
  parse_phase_t parse_phase = P_SIG;
  logic [1:0]   field_pos   = '0;
  logic [31:0]  field_acc   = '0;
  logic [31:0]  rec_type    = '0;
  logic [7:0]   rec_comp    = '0;
  logic [31:0]  rec_size    = '0;
  logic [31:0]  data_left   = '0;
  logic [15:0]  data_sum    = '0;

  // Folds one byte into the little-endian field being gathered and reports
  // whether the field now holds nbytes bytes.
  function automatic bit gather_le_byte(input logic [7:0] b, input int unsigned nbytes);
    int unsigned pos;
    pos = field_pos;
    field_acc = field_acc | (32'(b) << (8 * pos));
    if (pos + 1 >= nbytes) begin
      field_pos = '0;
      return 1'b1;
    end
    field_pos = 2'(pos + 1);
    return 1'b0;
  endfunction

  // Advances the predicted parser by one accepted byte and records the event
  // that byte should cause, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic restart);
    tnef_pkg::tnef_event_t ev;
    logic [31:0] word;
    bit          emit;
    ev   = '0;
    emit = 1'b0;
    // A restart clears everything, then the byte opens the signature.
    if (restart) begin
      parse_phase = P_SIG;
      field_pos   = '0;
      field_acc   = '0;
      rec_type    = '0;
      rec_comp    = '0;
      rec_size    = '0;
      data_left   = '0;
      data_sum    = '0;
    end
    case (parse_phase)
      P_SIG: begin
        if (gather_le_byte(b, 4)) begin
          word      = field_acc;
          field_acc = '0;
          if (word == tnef_pkg::SIGNATURE_WORD) begin
            parse_phase = P_KEY;
          end else begin
            // The error event carries an all-zero record description.
            parse_phase   = P_HALT;
            ev.event_kind = tnef_pkg::EV_SIG_ERR;
            emit          = 1'b1;
          end
        end
      end
      P_KEY: begin
        if (gather_le_byte(b, 2)) begin
          field_acc   = '0;
          parse_phase = P_COMP;
        end
      end
      P_COMP: begin
        rec_comp    = b;
        field_pos   = '0;
        field_acc   = '0;
        parse_phase = P_TYPE;
      end
      P_TYPE: begin
        if (gather_le_byte(b, 4)) begin
          rec_type    = field_acc;
          field_acc   = '0;
          parse_phase = P_LEN;
        end
      end
      P_LEN: begin
        if (gather_le_byte(b, 4)) begin
          rec_size    = field_acc;
          data_left   = field_acc;
          field_acc   = '0;
          data_sum    = '0;
          // An empty record has neither data nor a checksum word.
          parse_phase = (rec_size == 0) ? P_COMP : P_DATA;
        end
      end
      P_DATA: begin
        data_sum  = data_sum + 16'(b);
        data_left = data_left - 1;
        ev.event_kind     = tnef_pkg::EV_DATA;
        ev.attribute_type = rec_type;
        ev.component      = rec_comp;
        ev.payload_byte   = b;
        ev.record_length  = rec_size;
        ev.last_of_record = (data_left == 0);
        emit = 1'b1;
        if (data_left == 0) begin
          field_pos   = '0;
          field_acc   = '0;
          parse_phase = P_CSUM;
        end
      end
      P_CSUM: begin
        if (gather_le_byte(b, 2)) begin
          word      = field_acc;
          field_acc = '0;
          ev.attribute_type = rec_type;
          ev.component      = rec_comp;
          ev.record_length  = rec_size;
          emit = 1'b1;
          if (word[15:0] == data_sum) begin
            parse_phase   = P_COMP;
            ev.event_kind = tnef_pkg::EV_CSUM_OK;
          end else begin
            parse_phase   = P_HALT;
            ev.event_kind = tnef_pkg::EV_CSUM_ERR;
          end
        end
      end
      default: begin
        // Halted: bytes are swallowed until the next restart.
      end
    endcase
    if (emit) begin
      expected_events.push_back(ev);
    end
  endtask

  // Compares one popped result with the oldest outstanding expectation.
  task automatic check_event(input tnef_pkg::tnef_event_t got);
    tnef_pkg::tnef_event_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("t=%0t unexpected result: kind %0d type %h comp %h byte %h len %h last %b",
                 $time, got.event_kind, got.attribute_type, got.component,
                 got.payload_byte, got.record_length, got.last_of_record);
      end
    end else begin
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind || got.attribute_type !== want.attribute_type ||
          got.component !== want.component || got.payload_byte !== want.payload_byte ||
          got.record_length !== want.record_length ||
          got.last_of_record !== want.last_of_record) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("t=%0t mismatch: expected kind %0d type %h comp %h byte %h len %h last %b",
                   $time, want.event_kind, want.attribute_type, want.component,
                   want.payload_byte, want.record_length, want.last_of_record);
          $display("              actual   kind %0d type %h comp %h byte %h len %h last %b",
                   got.event_kind, got.attribute_type, got.component,
                   got.payload_byte, got.record_length, got.last_of_record);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic restart, input bit counted);
    stream_item_t item;
    item.data    = b;
    item.restart = restart;
    pending_bytes.push_back(item);
    if (counted) begin
      counted_items++;
    end
  endtask

  // Queues the low nbytes of a word, least significant byte first; the
  // restart flag, if given, goes on the first of them.
  task automatic queue_le(input logic [31:0] w, input int unsigned nbytes,
                          input logic restart);
    for (int i = 0; i < nbytes; i++) begin
      queue_byte(w[8*i +: 8], (i == 0) ? restart : 1'b0, 1'b1);
    end
  endtask

  // Bytes sent into a halted parser: they exercise the halt but prove nothing
  // else, so they are not counted as stimulus.
  task automatic queue_ignored(input int unsigned n);
    repeat (n) queue_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  // One random stream: mostly well formed so that records get parsed, with a
  // share of bad signatures, corrupted checksums, huge lengths and streams that
  // stop part-way through a record header (the next stream restarts anyway).
  task automatic queue_random_stream();
    logic [31:0] sig;
    logic [31:0] rlen;
    logic [15:0] sum;
    logic [15:0] csum;
    logic [7:0]  d;
    int unsigned pick;
    bit          huge;
    bit          heavy;
    pick = $urandom_range(99);
    if (pick < 90) begin
      sig = tnef_pkg::SIGNATURE_WORD;
    end else if (pick < 95) begin
      sig = tnef_pkg::SIGNATURE_WORD ^ (32'd1 << $urandom_range(31));
    end else begin
      sig = $urandom;
    end
    queue_le(sig, 4, 1'b1);
    if (sig != tnef_pkg::SIGNATURE_WORD) begin
      queue_ignored($urandom_range(3));
      return;
    end
    queue_le($urandom, 2, 1'b0);
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(99) < 4) begin
        repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), 1'b0, 1'b1);
        return;
      end
      pick  = $urandom_range(99);
      huge  = 1'b0;
      heavy = 1'b0;
      if (pick < 15) begin
        rlen = '0;
      end else if (pick < 97) begin
        rlen = $urandom_range(1, 12);
      end else if (pick < 99) begin
        // Long records of large bytes can make the 16-bit sum wrap.
        rlen  = $urandom_range(258, 320);
        heavy = 1'b1;
      end else begin
        rlen = $urandom | 32'h8000_0000;
        huge = 1'b1;
      end
      queue_byte(8'($urandom), 1'b0, 1'b1);
      queue_le($urandom, 4, 1'b0);
      queue_le(rlen, 4, 1'b0);
      if (huge) begin
        // The stream ends long before this record could.
        repeat ($urandom_range(1, 16)) queue_byte(8'($urandom), 1'b0, 1'b1);
        return;
      end
      if (rlen != 0) begin
        sum = '0;
        repeat (rlen) begin
          d   = heavy ? 8'($urandom_range(200, 255)) : 8'($urandom);
          sum = sum + 16'(d);
          queue_byte(d, 1'b0, 1'b1);
        end
        csum = sum;
        if ($urandom_range(99) < 10) begin
          csum = sum ^ (16'd1 << $urandom_range(15));
        end
        queue_le(32'(csum), 2, 1'b0);
        if (csum != sum) begin
          queue_ignored($urandom_range(3));
          return;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver: offers the head of the pending queue at falling edges, idling at random outside
  // the quiet window, and retires it once the monitor has seen the request taken.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    bit offer;
    if (rst_n) begin
      if (byte_taken) begin
        void'(pending_bytes.pop_front());
      end
      offer = (pending_bytes.size() != 0) &&
              (quiet_window || ($urandom_range(99) >= IDLE_PERCENT));
      push <= offer;
      if (offer) begin
        in_stream_byte <= pending_bytes[0].data;
        in_restart     <= pending_bytes[0].restart;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: pops most cycles, with random gaps, and once holds off
  // for a long stretch so that the result queue fills and full rises while
  // the driver keeps offering requests.
  // ---------------------------------------------------------------------
  int unsigned rx_hold_left = 0;
  bit          rx_hold_done = 1'b0;

  always @(negedge clk) begin
    bit want_pop;
    if (rst_n) begin
      want_pop = 1'b1;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        want_pop = 1'b0;
      end else if (!rx_hold_done && inputs_taken >= RX_HOLD_AFTER) begin
        rx_hold_done = 1'b1;
        rx_hold_left = RX_HOLD_CYCLES;
        want_pop     = 1'b0;
      end else if (!quiet_window && $urandom_range(99) < IDLE_PERCENT) begin
        want_pop = 1'b0;
      end
      pop <= want_pop;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. Results are checked
  // before the byte of the same edge is predicted, since a byte's event can
  // appear no earlier than the following cycle. The watchdog counts edges at
  // which no request moves on either side.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tnef_pkg::tnef_event_t got;
    bit          moved;
    if (rst_n) begin
      cycle_count++;
      byte_taken = push && !full;
      moved      = byte_taken;
      if (pop && !empty) begin
        got.event_kind     = out_event_kind;
        got.attribute_type = out_attribute_type;
        got.component      = out_component;
        got.payload_byte   = out_payload_byte;
        got.record_length  = out_record_length;
        got.last_of_record = out_last_of_record;
        check_event(got);
        moved = 1'b1;
      end
      if (byte_taken) begin
        deframe_byte(in_stream_byte, in_restart);
        inputs_taken++;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("t=%0t watchdog: no request accepted for %0d cycles, %0d results owed",
                   $time, STALL_LIMIT, expected_events.size());
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing: build the stimulus, reset, then wait for everything to drain.
  // ---------------------------------------------------------------------
  initial begin
    // Signature of all ones: the error comes on the fourth byte.
    queue_le(32'hFFFF_FFFF, 4, 1'b1);
    // A good stream with an all-ones key.
    queue_le(tnef_pkg::SIGNATURE_WORD, 4, 1'b1);
    queue_le(32'h0000_FFFF, 2, 1'b0);
    // Empty record with an all-ones component and type: no data, no checksum word.
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_le(32'hFFFF_FFFF, 4, 1'b0);
    queue_le(32'h0000_0000, 4, 1'b0);
    // One-byte record with an all-zero component and type and a checksum word that
    // is off in its high byte, so the parser halts.
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_le(32'h0000_0000, 4, 1'b0);
    queue_le(32'h0000_0001, 4, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_le(32'h0000_01FF, 2, 1'b0);
    queue_ignored(1);

    while (counted_items < STREAM_ITEMS) begin
      queue_random_stream();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
